FILE: rtl/lmsf_pkg.sv
// shared types and constants for the lms adaptive fir
package lmsf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 16;
  localparam int MU_ERR_W = STEP_W + SAMPLE_W + 1;

  localparam logic [STEP_W-1:0] STEP_RESET = 16'd328;

  // opcodes of the input word
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_CLR_HIST = 2'd1;
  localparam logic [1:0] OP_CLR_ALL  = 2'd2;

  // register index as selected by paddr[2]
  localparam logic REG_STEP_SIZE = 1'b0;

  typedef struct packed {
    logic valid;
    logic last;
  } tap_ctl_t;

endpackage

FILE: rtl/lmsf_tap_unit.sv
// shared multiply-accumulate and weight update pipeline, one tap per cycle
module lmsf_tap_unit #(
  parameter int TAPS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lmsf_pkg::tap_ctl_t                    ctl,
  input  logic [$clog2(TAPS)-1:0]               tap_idx,
  input  logic signed [lmsf_pkg::WEIGHT_W-1:0]  weight,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [lmsf_pkg::MU_ERR_W-1:0]  mu_err,
  input  logic                                  acc_clr,
  output logic                                  wb_en,
  output logic [$clog2(TAPS)-1:0]               wb_idx,
  output logic signed [lmsf_pkg::WEIGHT_W-1:0]  wb_weight,
  output logic                                  done,
  output logic signed [lmsf_pkg::WEIGHT_W+lmsf_pkg::SAMPLE_W+$clog2(TAPS):0] acc
);
  import lmsf_pkg::*;

  localparam int IW    = $clog2(TAPS);
  localparam int PY_W  = WEIGHT_W + SAMPLE_W;
  localparam int PU_W  = MU_ERR_W + SAMPLE_W;
  localparam int DLT_W = PU_W - 18;
  localparam int ACC_W = PY_W + IW + 1;

  // stage 2: products
  logic                   v2;
  logic                   l2;
  logic [IW-1:0]          i2;
  logic signed [PY_W-1:0] py;
  logic signed [PU_W-1:0] pu;
  logic signed [WEIGHT_W-1:0] w2;

  // stage 3: rounded step and old weight
  logic                    v3;
  logic                    l3;
  logic [IW-1:0]           i3;
  logic signed [DLT_W-1:0] dlt;
  logic signed [WEIGHT_W-1:0] w3;

  logic [PU_W-1:0]     pu_rnd;
  logic [WEIGHT_W:0]   w_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v2 <= ctl.valid;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    l2 <= ctl.last;
    i2 <= tap_idx;
    w2 <= weight;
    py <= weight * sample;
    pu <= mu_err * sample;
  end

  // round half up to q4.28 by add and floor shift
  assign pu_rnd = pu + PU_W'(2**17);

  always_ff @(posedge clk) begin
    l3  <= l2;
    i3  <= i2;
    w3  <= w2;
    dlt <= pu_rnd[PU_W-1:18];
  end

  always_ff @(posedge clk) begin
    if (acc_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + {{(ACC_W-PY_W){py[PY_W-1]}}, py};
    end
  end

  assign w_sum = {w3[WEIGHT_W-1], w3}
               + {{(WEIGHT_W+1-DLT_W){dlt[DLT_W-1]}}, dlt};

  always_comb begin
    if (w_sum[WEIGHT_W] != w_sum[WEIGHT_W-1]) begin
      wb_weight = {w_sum[WEIGHT_W], {(WEIGHT_W-1){~w_sum[WEIGHT_W]}}};
    end else begin
      wb_weight = w_sum[WEIGHT_W-1:0];
    end
  end

  assign wb_en  = v3;
  assign wb_idx = i3;
  assign done   = v3 & l3;

endmodule

FILE: rtl/lms_adaptive_fir.sv
// top level of the lms adaptive fir: sequencer, history and weight memories
//
// input channel (in_valid/in_stall) carries one word: opcode, primary_sample,
// error_sample. opcode sample writes primary_sample into the history ring,
// returns one output word (filter_output, saturated) on out_valid/out_stall,
// and updates every weight with step_size * error_sample * history.
// opcode clear history and clear all return no word; unused opcode is dropped.
// for a sample word, one shared multiplier pair walks the taps at one memory
// read per cycle, then the pipeline drains and the output is rounded before
// the next word is taken.
// a clear word clears one entry per cycle before the next word is taken.
// after reset the block runs a clearing pass over both memories,
// with in_stall high; step_size returns to 328 and apb writes work throughout.
// the output register parts the two sides: a new word is taken while the last
// result waits; a stalled receiver only holds the block at the rounding step.
// step_size sits at byte address 0 of the apb port, pready is always high.
module lms_adaptive_fir #(
  parameter int TAPS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0] primary_sample,
  input  logic signed [lmsf_pkg::SAMPLE_W-1:0] error_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [lmsf_pkg::SAMPLE_W-1:0] filter_output,
  output logic                                 saturated,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import lmsf_pkg::*;

  localparam int IW    = $clog2(TAPS);
  localparam int ACC_W = WEIGHT_W + SAMPLE_W + IW + 1;
  localparam int YW    = ACC_W - 28;
  localparam logic [IW-1:0] LAST_TAP = IW'(TAPS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;

  logic [2:0]        state;
  logic [IW-1:0]     cnt;
  logic [IW-1:0]     wp;
  logic [IW-1:0]     rp;
  logic              clr_w;
  logic [STEP_W-1:0] step_size;
  logic signed [MU_ERR_W-1:0] mu_err;

  logic signed [SAMPLE_W-1:0] h_mem [TAPS];
  logic signed [WEIGHT_W-1:0] w_mem [TAPS];

  logic                       h_we;
  logic [IW-1:0]              h_waddr;
  logic signed [SAMPLE_W-1:0] h_wdata;
  logic                       w_we;
  logic [IW-1:0]              w_waddr;
  logic signed [WEIGHT_W-1:0] w_wdata;

  logic                       rd_v;
  logic                       rd_last;
  logic [IW-1:0]              rd_idx;
  logic signed [SAMPLE_W-1:0] rd_h;
  logic signed [WEIGHT_W-1:0] rd_w;

  tap_ctl_t                   tap_ctl;
  logic                       wb_en;
  logic [IW-1:0]              wb_idx;
  logic signed [WEIGHT_W-1:0] wb_weight;
  logic                       done;
  logic signed [ACC_W-1:0]    acc;

  logic              in_fire;
  logic              cfg_wr;
  logic              out_free;
  logic [ACC_W-1:0]  acc_rnd;
  logic [YW-1:0]     y_full;
  logic              y_ovf;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;

  // apb register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_STEP_SIZE);
  assign prdata = (paddr[2] == REG_STEP_SIZE) ? {{(32-STEP_W){1'b0}}, step_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= STEP_RESET;
    end else if (cfg_wr) begin
      step_size <= pwdata[STEP_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      wp    <= '0;
      clr_w <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            cnt <= '0;
            case (opcode)
              OP_SAMPLE: begin
                state <= ST_RUN;
                wp    <= (wp == LAST_TAP) ? '0 : wp + 1'b1;
              end
              OP_CLR_HIST: begin
                state <= ST_CLEAR;
                clr_w <= 1'b0;
                wp    <= '0;
              end
              OP_CLR_ALL: begin
                state <= ST_CLEAR;
                clr_w <= 1'b1;
                wp    <= '0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_TAP) begin
            state <= ST_IDLE;
          end
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_TAP) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // history read pointer walks newest to oldest
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rp <= wp;
    end else if (state == ST_RUN) begin
      rp <= (rp == '0) ? LAST_TAP : rp - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && opcode == OP_SAMPLE) begin
      mu_err <= $signed({1'b0, step_size}) * error_sample;
    end
  end

  // memory write ports
  always_comb begin
    h_we    = 1'b0;
    h_waddr = cnt;
    h_wdata = '0;
    if (state == ST_CLEAR) begin
      h_we = 1'b1;
    end else if (in_fire && opcode == OP_SAMPLE) begin
      h_we    = 1'b1;
      h_waddr = wp;
      h_wdata = primary_sample;
    end
  end

  always_comb begin
    w_we    = 1'b0;
    w_waddr = cnt;
    w_wdata = '0;
    if (state == ST_CLEAR) begin
      w_we = clr_w;
    end else if (wb_en) begin
      w_we    = 1'b1;
      w_waddr = wb_idx;
      w_wdata = wb_weight;
    end
  end

  // the new sample is written at acceptance, read no earlier than the next cycle
  always_ff @(posedge clk) begin
    if (h_we) begin
      h_mem[h_waddr] <= h_wdata;
    end
    rd_h <= h_mem[rp];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[w_waddr] <= w_wdata;
    end
    rd_w <= w_mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_RUN);
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= (cnt == LAST_TAP);
    rd_idx  <= cnt;
  end

  assign tap_ctl.valid = rd_v;
  assign tap_ctl.last  = rd_last;

  lmsf_tap_unit #(
    .TAPS (TAPS)
  ) u_tap (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tap_ctl),
    .tap_idx   (rd_idx),
    .weight    (rd_w),
    .sample    (rd_h),
    .mu_err    (mu_err),
    .acc_clr   (in_fire && opcode == OP_SAMPLE),
    .wb_en     (wb_en),
    .wb_idx    (wb_idx),
    .wb_weight (wb_weight),
    .done      (done),
    .acc       (acc)
  );

  // round half up to q1.15, then clip
  assign acc_rnd = acc + ACC_W'(2**27);
  assign y_full  = acc_rnd[ACC_W-1:28];
  assign y_ovf   = (y_full[YW-1:SAMPLE_W-1] != {(YW-SAMPLE_W+1){y_full[YW-1]}});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_ROUND && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_ROUND && out_free) begin
      saturated <= y_ovf;
      if (y_ovf) begin
        filter_output <= {y_full[YW-1], {(SAMPLE_W-1){~y_full[YW-1]}}};
      end else begin
        filter_output <= y_full[SAMPLE_W-1:0];
      end
    end
  end

  a_out_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_ROUND))
    else $error("output word without a finished tap pass");

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_DRAIN)
    else $error("last tap completed outside drain");

  a_wb_in_pass: assert property (@(posedge clk) disable iff (rst)
    wb_en |-> (state == ST_RUN || state == ST_DRAIN))
    else $error("weight write-back outside a tap pass");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_CLEAR) |=> !$past(in_fire))
    else $error("word accepted while memories busy");

endmodule
